FILE: sv/xbo_pkg.sv
package xbo_pkg;

    // Register file geometry.
    localparam int unsigned XBO_NUM_REGS  = 16;
    localparam int unsigned XBO_REG_WIDTH = 64;
    localparam int unsigned XBO_REG_AW    = 4;

    // Command codes.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Register index of the flags word.
    localparam logic [4:0] FLAGS_INDEX = 5'd16;

    // Opcode and prefix bytes.
    localparam logic [7:0] BYTE_REP    = 8'hF3;
    localparam logic [7:0] BYTE_ESC    = 8'h0F;
    localparam logic [7:0] BYTE_POPCNT = 8'hB8;
    localparam logic [7:0] BYTE_VEX3   = 8'hC4;
    localparam logic [4:0] VEX_MAP_0F38 = 5'h02;
    localparam logic [7:0] BYTE_ANDN   = 8'hF2;
    localparam logic [7:0] BYTE_BLS    = 8'hF3;
    localparam logic [3:0] REX_HIGH    = 4'h4;
    localparam logic [1:0] MOD_REG     = 2'b11;

    // ModRM reg-field selectors of the BLS group.
    localparam logic [2:0] SEL_BLSR   = 3'd1;
    localparam logic [2:0] SEL_BLSMSK = 3'd2;
    localparam logic [2:0] SEL_BLSI   = 3'd3;

    // Instruction lengths.
    localparam logic [2:0] LEN_SHORT = 3'd4;
    localparam logic [2:0] LEN_LONG  = 3'd5;

    localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

    // Flag bits.
    localparam logic [63:0] FL_CF = 64'h0000_0000_0000_0001;
    localparam logic [63:0] FL_PF = 64'h0000_0000_0000_0004;
    localparam logic [63:0] FL_AF = 64'h0000_0000_0000_0010;
    localparam logic [63:0] FL_ZF = 64'h0000_0000_0000_0040;
    localparam logic [63:0] FL_SF = 64'h0000_0000_0000_0080;
    localparam logic [63:0] FL_OF = 64'h0000_0000_0000_0800;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_POPCNT,
        OP_ANDN,
        OP_BLSR,
        OP_BLSMSK,
        OP_BLSI
    } xbo_op_t;

    // Request and response payloads.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  reg_index;
        logic [63:0] write_value;
        logic [39:0] inst_bytes;
    } xbo_req_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  inst_length;
        logic [63:0] read_value;
    } xbo_rsp_t;

    // Decoded instruction fields.
    typedef struct packed {
        xbo_op_t                 op;
        logic                    wide;
        logic [XBO_REG_AW-1:0]   addr_a;
        logic [XBO_REG_AW-1:0]   addr_b;
        logic [XBO_REG_AW-1:0]   dst;
        logic [2:0]              length;
    } xbo_dec_t;

    // Writeback to the register file and flags.
    typedef struct packed {
        logic                    gpr_we;
        logic [XBO_REG_AW-1:0]   gpr_addr;
        logic [63:0]             gpr_data;
        logic                    flags_we;
        logic [63:0]             flags_data;
    } xbo_wb_t;

    // Population count of a 64-bit word, reduced in parallel steps.
    function automatic logic [6:0] popcount64(input logic [63:0] v);
        logic [63:0] s1;
        logic [63:0] s2;
        logic [63:0] s3;
        logic [6:0]  sum;
        s1  = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        s2  = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
        s3  = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        sum = '0;
        for (int k = 0; k < 8; k++)
        begin
            sum = sum + {3'b000, s3[8*k +: 4]};
        end
        return sum;
    endfunction

endpackage

FILE: sv/xbo_stream_if.sv
interface xbo_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/xbo_ram.sv
module xbo_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; a read returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/xbo_decode.sv
module xbo_decode import xbo_pkg::*; (
    input  xbo_req_t req,
    output xbo_dec_t dec
);
    logic [7:0] b0, b1, b2, b3, b4;
    logic       rex;
    logic [7:0] pc_op0, pc_op1, pc_modrm;
    logic       is_popcnt;
    logic       vex_ok;
    logic [2:0] sel;
    logic [3:0] vvvv;
    logic [3:0] mreg;
    logic [3:0] mrm;

    assign b0 = req.inst_bytes[7:0];
    assign b1 = req.inst_bytes[15:8];
    assign b2 = req.inst_bytes[23:16];
    assign b3 = req.inst_bytes[31:24];
    assign b4 = req.inst_bytes[39:32];

    // POPCNT with an optional REX prefix.
    assign rex       = (b1[7:4] == REX_HIGH);
    assign pc_op0    = rex ? b2 : b1;
    assign pc_op1    = rex ? b3 : b2;
    assign pc_modrm  = rex ? b4 : b3;
    assign is_popcnt = (b0 == BYTE_REP) && (pc_op0 == BYTE_ESC) && (pc_op1 == BYTE_POPCNT)
                       && (pc_modrm[7:6] == MOD_REG);

    // Three-byte VEX, map 0F38, L and pp zero, register operand.
    assign vex_ok = (b0 == BYTE_VEX3) && (b1[4:0] == VEX_MAP_0F38) && !b2[2]
                    && (b2[1:0] == 2'b00) && (b4[7:6] == MOD_REG);
    assign sel    = b4[5:3];
    assign vvvv   = ~b2[6:3];
    assign mreg   = {~b1[7], sel};
    assign mrm    = {~b1[5], b4[2:0]};

    always_comb
    begin
        dec        = '0;
        dec.op     = OP_NONE;
        dec.addr_a = req.reg_index[3:0];
        if (req.cmd == CMD_EXEC)
        begin
            if (is_popcnt)
            begin
                dec.op     = OP_POPCNT;
                dec.wide   = rex & b1[3];
                dec.dst    = {rex & b1[2], pc_modrm[5:3]};
                dec.addr_a = {rex & b1[0], pc_modrm[2:0]};
                dec.length = rex ? LEN_LONG : LEN_SHORT;
            end
            else if (vex_ok)
            begin
                dec.wide   = b2[7];
                dec.addr_a = mrm;
                dec.addr_b = vvvv;
                dec.length = LEN_LONG;
                if (b3 == BYTE_ANDN)
                begin
                    dec.op  = OP_ANDN;
                    dec.dst = mreg;
                end
                else if (b3 == BYTE_BLS)
                begin
                    dec.dst = vvvv;
                    case (sel)
                        SEL_BLSR:   dec.op = OP_BLSR;
                        SEL_BLSMSK: dec.op = OP_BLSMSK;
                        SEL_BLSI:   dec.op = OP_BLSI;
                        default:    dec.op = OP_NONE;
                    endcase
                end
            end
        end
    end
endmodule

FILE: sv/xbo_execute.sv
module xbo_execute import xbo_pkg::*; (
    input  xbo_req_t    req,
    input  xbo_dec_t    dec,
    input  logic [63:0] src_a,
    input  logic [63:0] src_b,
    input  logic [63:0] flags,
    output xbo_rsp_t    rsp,
    output xbo_wb_t     wb
);
    logic [63:0] op2;
    logic [63:0] op1;
    logic [63:0] dec2;
    logic [63:0] raw;
    logic [63:0] res;
    logic        cf;
    logic        zf;
    logic        sf;
    logic [6:0]  count;

    // Operands at the selected width.
    assign op2   = dec.wide ? src_a : (src_a & MASK32);
    assign op1   = dec.wide ? src_b : (src_b & MASK32);
    assign dec2  = op2 - 64'd1;
    assign count = popcount64(op2);

    // BMI1 result and carry.
    always_comb
    begin
        raw = '0;
        cf  = 1'b0;
        case (dec.op)
            OP_ANDN:
            begin
                raw = ~op1 & op2;
            end
            OP_BLSR:
            begin
                raw = op2 & dec2;
                cf  = (op2 == '0);
            end
            OP_BLSMSK:
            begin
                raw = op2 ^ dec2;
                cf  = (op2 == '0);
            end
            OP_BLSI:
            begin
                raw = op2 & (~op2 + 64'd1);
                cf  = (op2 != '0);
            end
            default:
            begin
                raw = '0;
            end
        endcase
    end

    assign res = dec.wide ? raw : (raw & MASK32);
    assign zf  = (dec.op != OP_BLSMSK) && (res == '0);
    assign sf  = dec.wide ? res[63] : res[31];

    // Response and writeback per command.
    always_comb
    begin
        rsp = '0;
        wb  = '0;
        case (req.cmd)
            CMD_WRITE:
            begin
                if (req.reg_index < FLAGS_INDEX)
                begin
                    wb.gpr_we   = 1'b1;
                    wb.gpr_addr = req.reg_index[3:0];
                    wb.gpr_data = req.write_value;
                end
                else if (req.reg_index == FLAGS_INDEX)
                begin
                    wb.flags_we   = 1'b1;
                    wb.flags_data = req.write_value;
                end
            end
            CMD_READ:
            begin
                if (req.reg_index < FLAGS_INDEX)
                begin
                    rsp.read_value = src_a;
                end
                else if (req.reg_index == FLAGS_INDEX)
                begin
                    rsp.read_value = flags;
                end
            end
            CMD_EXEC:
            begin
                if (dec.op == OP_NONE)
                begin
                    rsp.status = 1'b1;
                end
                else
                begin
                    rsp.inst_length = dec.length;
                    wb.gpr_we       = 1'b1;
                    wb.gpr_addr     = dec.dst;
                    wb.flags_we     = 1'b1;
                    if (dec.op == OP_POPCNT)
                    begin
                        wb.gpr_data   = {57'd0, count};
                        wb.flags_data = (flags & ~(FL_CF | FL_PF | FL_AF | FL_ZF | FL_SF | FL_OF))
                                        | ((count == '0) ? FL_ZF : 64'd0);
                    end
                    else
                    begin
                        wb.gpr_data   = res;
                        wb.flags_data = (flags & ~(FL_CF | FL_ZF | FL_SF | FL_OF))
                                        | (cf ? FL_CF : 64'd0)
                                        | (zf ? FL_ZF : 64'd0)
                                        | (sf ? FL_SF : 64'd0);
                    end
                end
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end
endmodule

FILE: sv/x86_bitop_decode_execute_core.sv
// An accepted item is held in the stage-1 registers with its register-file read, then
// executed, and its response is captured in the output register.
// Throughput: one item per cycle; the register-file read, ALU and popcount tree
// share the single execute stage. Stalls only when the output register is held.
// Reset clears all sixteen registers (through per-entry valid bits) and the flags word.
module x86_bitop_decode_execute_core import xbo_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    xbo_stream_if.sink   request,
    xbo_stream_if.source response
);
    xbo_dec_t              dec_next;
    logic                  accept;
    logic                  s1_fire;

    logic                  s1_valid_reg;
    xbo_req_t              s1_req_reg;
    xbo_dec_t              s1_dec_reg;
    logic                  vld_a_reg;
    logic                  vld_b_reg;

    logic [XBO_NUM_REGS-1:0] regvalid_reg;
    logic [63:0]           flags_reg;

    logic                  wb_en_reg;
    logic [XBO_REG_AW-1:0] wb_addr_reg;
    logic [63:0]           wb_data_reg;

    logic                  out_valid_reg;
    xbo_rsp_t              out_data_reg;

    logic [63:0]           ram_a;
    logic [63:0]           ram_b;
    logic [63:0]           src_a;
    logic [63:0]           src_b;
    xbo_rsp_t              rsp;
    xbo_wb_t               wb;

    // Handshake control.
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || response.ready);
    assign accept        = request.valid && request.ready;
    assign request.ready = !s1_valid_reg || s1_fire;

    // Decode register addresses ahead of the file read.
    xbo_decode u_decode (
        .req (request.data),
        .dec (dec_next)
    );

    // Two copies of the register file give two read ports.
    xbo_ram #(.WIDTH(XBO_REG_WIDTH), .DEPTH(XBO_NUM_REGS)) u_ram_a (
        .clk   (clk),
        .we    (s1_fire && wb.gpr_we),
        .waddr (wb.gpr_addr),
        .wdata (wb.gpr_data),
        .re    (accept),
        .raddr (dec_next.addr_a),
        .rdata (ram_a)
    );

    xbo_ram #(.WIDTH(XBO_REG_WIDTH), .DEPTH(XBO_NUM_REGS)) u_ram_b (
        .clk   (clk),
        .we    (s1_fire && wb.gpr_we),
        .waddr (wb.gpr_addr),
        .wdata (wb.gpr_data),
        .re    (accept),
        .raddr (dec_next.addr_b),
        .rdata (ram_b)
    );

    // Forward the last write, which may land on the edge of the read; never-written
    // entries read as zero.
    always_comb
    begin
        if (wb_en_reg && (wb_addr_reg == s1_dec_reg.addr_a))
        begin
            src_a = wb_data_reg;
        end
        else
        begin
            src_a = vld_a_reg ? ram_a : 64'd0;
        end
        if (wb_en_reg && (wb_addr_reg == s1_dec_reg.addr_b))
        begin
            src_b = wb_data_reg;
        end
        else
        begin
            src_b = vld_b_reg ? ram_b : 64'd0;
        end
    end

    xbo_execute u_execute (
        .req   (s1_req_reg),
        .dec   (s1_dec_reg),
        .src_a (src_a),
        .src_b (src_b),
        .flags (flags_reg),
        .rsp   (rsp),
        .wb    (wb)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_en_reg     <= 1'b0;
            regvalid_reg  <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            if (request.ready)
            begin
                s1_valid_reg <= request.valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                wb_en_reg     <= wb.gpr_we;
                if (wb.gpr_we)
                begin
                    regvalid_reg[wb.gpr_addr] <= 1'b1;
                end
                if (wb.flags_we)
                begin
                    flags_reg <= wb.flags_data;
                end
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= request.data;
            s1_dec_reg <= dec_next;
            vld_a_reg  <= regvalid_reg[dec_next.addr_a];
            vld_b_reg  <= regvalid_reg[dec_next.addr_b];
        end
        if (s1_fire)
        begin
            out_data_reg <= rsp;
            wb_addr_reg  <= wb.gpr_addr;
            wb_data_reg  <= wb.gpr_data;
        end
    end

    assign response.valid = out_valid_reg;
    assign response.data  = out_data_reg;
endmodule
